### rtl/core/dsha_pkg.sv
`default_nettype none
package dsha_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] state_type;
   typedef word_type [15:0] block_type;

   typedef struct packed {
      logic [63:0] midstate_01;
      logic [63:0] midstate_23;
      logic [63:0] midstate_45;
      logic [63:0] midstate_67;
      logic [63:0] data_0;
      logic [63:0] data_1;
      logic [63:0] data_2;
      logic [63:0] data_3;
      logic [63:0] data_4;
      logic [63:0] data_5;
      logic [63:0] data_6;
      logic [63:0] nonce;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_0;
      logic [63:0] hash_1;
      logic [63:0] hash_2;
      logic [63:0] hash_3;
   } rsp_type;

   // data carried from one round cell to the next
   typedef struct packed {
      state_type work;
      block_type win;
      state_type chain;
   } round_type;

   localparam int unsigned Rounds = 64;

   localparam word_type PAD_WORD = 32'h80000000;
   localparam word_type LEN_4096 = 32'd4096;
   localparam word_type LEN_256  = 32'd256;

   localparam state_type STD_IV = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type bswap(input word_type x);
      bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage
`default_nettype wire

### rtl/core/dsha_round.sv
`default_nettype none
module dsha_round (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire dsha_pkg::word_type  k,
   input  wire logic                in_valid,
   input  wire dsha_pkg::round_type in_data,
   output logic                     out_valid,
   output dsha_pkg::round_type      out_data
);
   import dsha_pkg::*;

   logic      valid_ff;
   round_type data_ff, data_in;
   word_type  s1, ch, t1, s0, maj, t2, sg0, sg1, w_new;
   state_type v;
   block_type w;

   always_comb begin
      v   = in_data.work;
      w   = in_data.win;
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = v[6] ^ (v[4] & (v[5] ^ v[6]));
      t1  = v[7] + s1 + ch + k + w[0];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) | (v[2] & (v[0] | v[1]));
      t2  = s0 + maj;
      // schedule word that enters the window at the far end
      sg0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
      sg1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
      w_new = sg1 + w[9] + sg0 + w[0];

      data_in.chain = in_data.chain;
      data_in.work  = {v[6:4], v[3] + t1, v[2:0], t1 + t2};
      data_in.win   = {w_new, w[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

### rtl/core/dsha_compress.sv
`default_nettype none
module dsha_compress (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire dsha_pkg::state_type in_chain,
   input  wire dsha_pkg::block_type in_block,
   output logic                     out_valid,
   output dsha_pkg::state_type      out_chain
);
   import dsha_pkg::*;

   logic      valid [0:Rounds];
   round_type data  [0:Rounds];
   logic      valid_ff;
   state_type chain_ff, chain_in;

   assign valid[0]      = in_valid;
   assign data[0].work  = in_chain;
   assign data[0].win   = in_block;
   assign data[0].chain = in_chain;

   for (genvar i = 0; i < Rounds; i++) begin : g_round
      dsha_round u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .k        (ROUND_K[i]),
         .in_valid (valid[i]),
         .in_data  (data[i]),
         .out_valid(valid[i+1]),
         .out_data (data[i+1])
      );
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         chain_in[j] = data[Rounds].chain[j] + data[Rounds].work[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid[Rounds];
      end
      if (advance) begin
         chain_ff <= chain_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_chain = chain_ff;
endmodule
`default_nettype wire

### rtl/core/double_sha256_nonce_hasher.sv
// Double SHA-256 nonce hasher.
// req channel: one item holds a midstate, 56 message bytes and a nonce.
// rsp channel: one item holds the 32-byte final digest, byte 0 in hash_0[7:0].
// Three compressions run as chains of 64 round cells, each followed by a
// feed-forward add register: 65 stages per compression, 195 in all.
// One item is taken every cycle while the chain is not held, the rate
// set by the round cell, one round per stage.
// The last feed-forward register is the output register.
// While rsp_valid is high and rsp_stall is high the whole chain holds and
// req_stall is raised; items in flight keep their place and none is lost.
// Bubbles (cycles without req_valid) travel down the chain as empty slots.
// Reset clears every stage's valid bit; the chain is empty afterwards.
`default_nettype none
module double_sha256_nonce_hasher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dsha_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dsha_pkg::rsp_type      rsp
);
   import dsha_pkg::*;

   logic      advance;
   logic      v1, v2, v3;
   state_type cv0, cv1, cv2, cv3;
   block_type blk1, blk2, blk3;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign cv0 = {req.midstate_67, req.midstate_45, req.midstate_23, req.midstate_01};

   always_comb begin
      blk1 = {bswap(req.nonce[63:32]),  bswap(req.nonce[31:0]),
              bswap(req.data_6[63:32]), bswap(req.data_6[31:0]),
              bswap(req.data_5[63:32]), bswap(req.data_5[31:0]),
              bswap(req.data_4[63:32]), bswap(req.data_4[31:0]),
              bswap(req.data_3[63:32]), bswap(req.data_3[31:0]),
              bswap(req.data_2[63:32]), bswap(req.data_2[31:0]),
              bswap(req.data_1[63:32]), bswap(req.data_1[31:0]),
              bswap(req.data_0[63:32]), bswap(req.data_0[31:0])};
      blk2     = '0;
      blk2[0]  = PAD_WORD;
      blk2[15] = LEN_4096;
      blk3      = '0;
      blk3[7:0] = cv2;
      blk3[8]   = PAD_WORD;
      blk3[15]  = LEN_256;
   end

   dsha_compress u_first (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_chain(cv0), .in_block(blk1),
      .out_valid(v1), .out_chain(cv1)
   );

   dsha_compress u_pad (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v1), .in_chain(cv1), .in_block(blk2),
      .out_valid(v2), .out_chain(cv2)
   );

   dsha_compress u_second (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v2), .in_chain(STD_IV), .in_block(blk3),
      .out_valid(v3), .out_chain(cv3)
   );

   assign rsp_valid  = v3;
   assign rsp.hash_0 = {bswap(cv3[1]), bswap(cv3[0])};
   assign rsp.hash_1 = {bswap(cv3[3]), bswap(cv3[2])};
   assign rsp.hash_2 = {bswap(cv3[5]), bswap(cv3[4])};
   assign rsp.hash_3 = {bswap(cv3[7]), bswap(cv3[6])};
endmodule
`default_nettype wire

### rtl/core/dsha_checker.sv
`default_nettype none
module dsha_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire dsha_pkg::rsp_type rsp
);
   import dsha_pkg::*;

   // chain is frozen exactly when the output item is held
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output hold");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
endmodule

bind double_sha256_nonce_hasher dsha_checker u_checker (.*);
`default_nettype wire
